### rtl/core/escape_rle_byte_decoder_macros.svh
// Assertion helpers used by the decoder's parser module.
// Each expects clk_i and rst_ni to be visible where it is used.
`ifndef ESCAPE_RLE_BYTE_DECODER_MACROS_SVH
`define ESCAPE_RLE_BYTE_DECODER_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define ERBD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ERBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/erbd_pkg.sv
package erbd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;
  localparam int unsigned TotalW = 21;

  localparam logic [ByteW-1:0]  EscCode   = 8'hC0;
  localparam logic [ByteW-1:0]  ShortMask = 8'h3F;
  localparam logic [TotalW-1:0] CapReset  = 21'd1024;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusTruncate = 2'd1,
    StatusOverflow = 2'd2
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             in_last;
  } in_word_t;

  typedef struct packed {
    logic [ByteW-1:0]  run_value;
    logic [CountW-1:0] run_length;
    logic [TotalW-1:0] total_length;
    status_e           status;
    logic              end_of_stream;
  } res_word_t;

endpackage

### rtl/core/erbd_if.sv
interface erbd_in_if;
  logic                         valid;
  logic                         ready;
  logic [erbd_pkg::ByteW-1:0]   in_byte;
  logic                         in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface erbd_out_if;
  logic                         valid;
  logic                         ready;
  logic [erbd_pkg::ByteW-1:0]   run_value;
  logic [erbd_pkg::CountW-1:0]  run_length;
  logic [erbd_pkg::TotalW-1:0]  total_length;
  logic [1:0]                   status;
  logic                         end_of_stream;

  modport source (output valid, output run_value, output run_length, output total_length,
                  output status, output end_of_stream, input ready);
  modport sink   (input valid, input run_value, input run_length, input total_length,
                  input status, input end_of_stream, output ready);
endinterface

interface erbd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [erbd_pkg::TotalW-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/erbd_in_stage.sv
module erbd_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  erbd_pkg::in_word_t word_i,
  input  logic               adv_i,
  output logic               vld_o,
  output erbd_pkg::in_word_t word_o
);

  logic               vld_q;
  erbd_pkg::in_word_t word_q;

  // The held word moves on whenever the result register can take its outcome.
  assign ready_o = !vld_q || adv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_i;
    end
  end

  assign vld_o  = vld_q;
  assign word_o = word_q;

endmodule

### rtl/core/erbd_parser.sv
`include "escape_rle_byte_decoder_macros.svh"

module erbd_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [erbd_pkg::TotalW-1:0]   cfg_data_i,
  input  logic                          step_i,
  input  erbd_pkg::in_word_t            word_i,
  output logic                          res_vld_o,
  output erbd_pkg::res_word_t           res_o
);

  localparam logic [2:0] PhIdle     = 3'd0;
  localparam logic [2:0] PhShortVal = 3'd1;
  localparam logic [2:0] PhLongLo   = 3'd2;
  localparam logic [2:0] PhLongHi   = 3'd3;
  localparam logic [2:0] PhLongVal  = 3'd4;

  logic [2:0]                  phase_q, phase_d;
  logic [erbd_pkg::CountW-1:0] count_q, count_d;
  logic [erbd_pkg::TotalW-1:0] total_q, total_d;
  logic                        drain_q, drain_d;
  logic [erbd_pkg::TotalW-1:0] cap_q;

  logic                        run_go;
  logic [erbd_pkg::CountW-1:0] run_len;
  logic                        trunc;
  logic [erbd_pkg::TotalW:0]   sum;
  logic                        full;
  logic [erbd_pkg::ByteW-1:0]  b;
  logic                        last;

  assign b    = word_i.in_byte;
  assign last = word_i.in_last;

  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    total_d   = total_q;
    drain_d   = drain_q;
    run_go    = 1'b0;
    run_len   = count_q;
    trunc     = 1'b0;
    res_vld_o = 1'b0;
    res_o     = '0;
    sum       = '0;
    full      = 1'b0;

    if (drain_q) begin
      // Everything up to the end of the stream is swallowed.
      if (last) begin
        drain_d = 1'b0;
        phase_d = PhIdle;
        count_d = '0;
        total_d = '0;
      end
    end else begin
      case (phase_q)
        PhShortVal, PhLongVal: begin
          phase_d = PhIdle;
          run_go  = 1'b1;
        end
        PhLongLo: begin
          count_d = {{(erbd_pkg::CountW-erbd_pkg::ByteW){1'b0}}, b};
          phase_d = PhLongHi;
          trunc   = last;
        end
        PhLongHi: begin
          count_d = {b, count_q[erbd_pkg::ByteW-1:0]};
          phase_d = PhLongVal;
          trunc   = last;
        end
        default: begin
          phase_d = PhIdle;
          if (b < erbd_pkg::EscCode) begin
            run_go  = 1'b1;
            run_len = {{(erbd_pkg::CountW-1){1'b0}}, 1'b1};
          end else if (b == erbd_pkg::EscCode) begin
            count_d = '0;
            phase_d = PhLongLo;
            trunc   = last;
          end else begin
            count_d = {{(erbd_pkg::CountW-erbd_pkg::ByteW){1'b0}}, b & erbd_pkg::ShortMask};
            phase_d = PhShortVal;
            trunc   = last;
          end
        end
      endcase

      if (run_go) begin
        sum = {1'b0, total_q} + {{(erbd_pkg::TotalW+1-erbd_pkg::CountW){1'b0}}, run_len};
        res_vld_o        = 1'b1;
        res_o.run_value  = b;
        res_o.run_length = run_len;
        if (sum > {1'b0, cap_q}) begin
          // The run does not fit: report it without adding it to the total.
          res_o.total_length  = total_q;
          res_o.status        = erbd_pkg::StatusOverflow;
          res_o.end_of_stream = 1'b1;
          drain_d             = 1'b1;
        end else begin
          total_d             = sum[erbd_pkg::TotalW-1:0];
          full                = total_d >= cap_q;
          res_o.total_length  = total_d;
          res_o.status        = erbd_pkg::StatusOk;
          res_o.end_of_stream = last || full;
          drain_d             = full;
        end
      end else if (trunc) begin
        res_vld_o           = 1'b1;
        res_o.total_length  = total_q;
        res_o.status        = erbd_pkg::StatusTruncate;
        res_o.end_of_stream = 1'b1;
      end

      if (last) begin
        phase_d = PhIdle;
        count_d = '0;
        total_d = '0;
        drain_d = 1'b0;
      end
    end

    if (!step_i) begin
      res_vld_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      count_q <= '0;
      total_q <= '0;
      drain_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      total_q <= total_d;
      drain_q <= drain_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= erbd_pkg::CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  `ERBD_ASSERT_NEXT(a_last_clears, step_i && word_i.in_last, phase_q == PhIdle && total_q == '0 && !drain_q, "stream state not cleared after final word")
  `ERBD_ASSERT_SAME(a_drain_idle, drain_q, phase_q == PhIdle, "draining while mid-escape")
  `ERBD_ASSERT_SAME(a_trunc_shape, res_vld_o && res_o.status == erbd_pkg::StatusTruncate, res_o.end_of_stream && res_o.run_length == '0 && res_o.run_value == '0, "malformed truncation result")
  `ERBD_ASSERT_NEXT(a_drain_entry, step_i && res_vld_o && res_o.status == erbd_pkg::StatusOverflow && !word_i.in_last, drain_q, "overflow did not start draining")

endmodule

### rtl/core/erbd_out_stage.sv
module erbd_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_vld_i,
  input  erbd_pkg::res_word_t res_i,
  output logic                adv_o,
  output logic                valid_o,
  input  logic                ready_i,
  output erbd_pkg::res_word_t res_o
);

  logic                vld_q;
  erbd_pkg::res_word_t res_q;

  // A new result may enter when the register is empty or being emptied.
  assign adv_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_o) begin
      vld_q <= res_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && res_vld_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

### rtl/core/escape_rle_byte_decoder.sv
// Escape-coded run-length decoder. Each compressed byte word entering on in_i yields at
// most one run descriptor on out_o: bytes below 0xC0 are literal runs of one, bytes above
// 0xC0 carry a six-bit count for the following value byte, and 0xC0 is followed by a
// 16-bit little-endian count and the value. The block takes one byte every cycle while
// the output side does not stall; a word is held in the input register and its result
// is then registered in the result register. The input side's ready follows the output
// side's ready combinationally through those two registers. The capacity register is
// written through cfg_i, which is always ready, and must only change while no stream
// word is in flight.
module escape_rle_byte_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  erbd_in_if.sink    in_i,
  erbd_out_if.source out_o,
  erbd_cfg_if.sink   cfg_i
);

  erbd_pkg::in_word_t  in_word;
  erbd_pkg::in_word_t  held_word;
  erbd_pkg::res_word_t res;
  erbd_pkg::res_word_t out_word;
  logic                held_vld;
  logic                adv;
  logic                res_vld;

  assign in_word.in_byte = in_i.in_byte;
  assign in_word.in_last = in_i.in_last;
  assign cfg_i.ready     = 1'b1;

  erbd_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .word_i  (in_word),
    .adv_i   (adv),
    .vld_o   (held_vld),
    .word_o  (held_word)
  );

  erbd_parser u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.data),
    .step_i     (held_vld && adv),
    .word_i     (held_word),
    .res_vld_o  (res_vld),
    .res_o      (res)
  );

  erbd_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .res_vld_i (res_vld),
    .res_i     (res),
    .adv_o     (adv),
    .valid_o   (out_o.valid),
    .ready_i   (out_o.ready),
    .res_o     (out_word)
  );

  assign out_o.run_value     = out_word.run_value;
  assign out_o.run_length    = out_word.run_length;
  assign out_o.total_length  = out_word.total_length;
  assign out_o.status        = out_word.status;
  assign out_o.end_of_stream = out_word.end_of_stream;

endmodule
